// ===== rtl/core/slq_pkg.sv =====
// slq_pkg: shared types and constants of the slot-linked request queue.
// Holds command codes, sequencer states and the result record.
// No dependencies.
package slq_pkg;

  // Default pool size and fixed field widths
  localparam int POOL_DEPTH_DEF = 16;
  localparam int CMD_W          = 4;
  localparam int IDX_IN_W       = 8;
  localparam int STATUS_W       = 4;
  localparam int CTX_W          = 32;
  localparam int LIM_W          = 5;
  localparam int SLOT_OUT_W     = 4;
  localparam int MAX_RESULTS    = 16;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_UNDEFINED = 4'd0;
  localparam logic [STATUS_W-1:0] STATUS_IDLE      = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 4'd0,
    CMD_POP     = 4'd1,
    CMD_REMOVE  = 4'd2,
    CMD_SET_ST  = 4'd3,
    CMD_GET_ST  = 4'd4,
    CMD_IS_FREE = 4'd5,
    CMD_SET_CTX = 4'd6,
    CMD_GET_CTX = 4'd7,
    CMD_COLLECT = 4'd8
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_ADD_SCAN,
    S_ADD_LINK,
    S_ADD_NEW,
    S_POP,
    S_RM_IDX,
    S_RM_SCAN,
    S_RM_FIN,
    S_ST_WR,
    S_GET_ST,
    S_GET_CTX,
    S_CL_RD,
    S_CL_CHK,
    S_CL_END
  } state_t;

  // One result transaction
  typedef struct packed {
    logic                  ok;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [STATUS_W-1:0]   status_out;
    logic [CTX_W-1:0]      context_out;
    logic                  slot_free;
    logic [LIM_W-1:0]      hit_count;
    logic                  last;
  } res_t;

endpackage

// ===== rtl/core/slq_ram.sv =====
// slq_ram: generic single-clock RAM, one write port and one read port.
// Read data is registered and holds when no read is issued.
// No dependencies.
module slq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/slot_linked_request_queue.sv =====
// slot_linked_request_queue: pool of slots kept as one singly linked FIFO.
// Uses slq_pkg (types, codes) and slq_ram (link/status and context stores).
//
// One command is taken at a time; in_ready is high only while the sequencer
// is idle, and a finished result waits in the output register without
// blocking the next command. Is free, set ctx and bad commands are answered
// from the dispatch state; get status, get ctx, set status and pop head
// first read a RAM; add scans the busy bits, one slot per cycle, for the
// lowest free slot; remove runs a pipelined scan of the link store for the
// predecessor; collect walks the list, and each step of the walk waits on
// the link store read before the next address is known. Link, status and
// context live in synchronous RAMs; busy, link-valid and written marks are
// flops cleared at reset, so no clearing pass is needed.
module slot_linked_request_queue import slq_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [IDX_IN_W-1:0] in_entry_index,
  input  logic [STATUS_W-1:0] in_status_value,
  input  logic [CTX_W-1:0]    in_context_value,
  input  logic [LIM_W-1:0]    in_max_matches,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_ok,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  output logic [STATUS_W-1:0] out_status_out,
  output logic [CTX_W-1:0]    out_context_out,
  output logic                out_slot_free,
  output logic [LIM_W-1:0]    out_hit_count,
  output logic                out_last
);

  localparam int IW   = $clog2(POOL_DEPTH);
  localparam int SW   = IW + 1;
  localparam int AW_A = IW + STATUS_W;

  // Sequencer and slot flags
  state_t            state_r, state_nxt;
  logic [POOL_DEPTH-1:0] busy_r, busy_nxt;
  logic [POOL_DEPTH-1:0] link_ok_r, link_ok_nxt;
  logic [POOL_DEPTH-1:0] st_v_r, st_v_nxt;
  logic [POOL_DEPTH-1:0] ctx_v_r, ctx_v_nxt;
  logic              head_ok_r, head_ok_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;

  // Latched command
  cmd_t              cmd_r, cmd_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              idx_ok_r, idx_ok_nxt;
  logic [STATUS_W-1:0] stv_r, stv_nxt;
  logic [CTX_W-1:0]  ctx_r, ctx_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;

  // Working registers
  logic [SW-1:0]     scan_r, scan_nxt;
  logic [IW-1:0]     free_r, free_nxt;
  logic [IW-1:0]     chk_r, chk_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [IW-1:0]     idx_link_r, idx_link_nxt;
  logic [IW-1:0]     pred_r, pred_nxt;
  logic              pred_found_r, pred_found_nxt;
  logic [STATUS_W-1:0] pred_st_r, pred_st_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic              cur_ok_r, cur_ok_nxt;
  logic [LIM_W-1:0]  cnt_r, cnt_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic [IW-1:0]     pend_r, pend_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  // RAM ports
  logic              a_wr_en, a_rd_en;
  logic [IW-1:0]     a_wr_addr, a_rd_addr;
  logic [AW_A-1:0]   a_wr_data, a_rd_data;
  logic              b_wr_en, b_rd_en;
  logic [IW-1:0]     b_wr_addr, b_rd_addr;
  logic [CTX_W-1:0]  b_wr_data, b_rd_data;

  logic [IW-1:0]     a_link;
  logic [STATUS_W-1:0] a_status;
  logic              out_free;
  logic              emit;
  res_t              res;
  logic              rm_match;
  logic              cl_match;
  logic [STATUS_W-1:0] cl_status;

  // Link/status store: {link, status}
  slq_ram #(
    .WIDTH (AW_A),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (a_wr_data),
    .rd_en   (a_rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  // Context store
  slq_ram #(
    .WIDTH (CTX_W),
    .DEPTH (POOL_DEPTH)
  ) u_ctx_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  assign a_link   = a_rd_data[AW_A-1:STATUS_W];
  assign a_status = a_rd_data[STATUS_W-1:0];
  assign out_free = !out_valid_r || out_ready;

  // Scan compares
  assign rm_match  = chk_v_r && link_ok_r[chk_r] && (a_link == idx_r);
  assign cl_status = st_v_r[cur_r] ? a_status : STATUS_UNDEFINED;
  assign cl_match  = (cl_status == stv_r);

  // Ports
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_res_r.ok;
  assign out_slot_index  = out_res_r.slot_index;
  assign out_status_out  = out_res_r.status_out;
  assign out_context_out = out_res_r.context_out;
  assign out_slot_free   = out_res_r.slot_free;
  assign out_hit_count   = out_res_r.hit_count;
  assign out_last        = out_res_r.last;

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    link_ok_nxt    = link_ok_r;
    st_v_nxt       = st_v_r;
    ctx_v_nxt      = ctx_v_r;
    head_ok_nxt    = head_ok_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    idx_ok_nxt     = idx_ok_r;
    stv_nxt        = stv_r;
    ctx_nxt        = ctx_r;
    lim_nxt        = lim_r;
    scan_nxt       = scan_r;
    free_nxt       = free_r;
    chk_nxt        = chk_r;
    chk_v_nxt      = chk_v_r;
    idx_link_nxt   = idx_link_r;
    pred_nxt       = pred_r;
    pred_found_nxt = pred_found_r;
    pred_st_nxt    = pred_st_r;
    cur_nxt        = cur_r;
    cur_ok_nxt     = cur_ok_r;
    cnt_nxt        = cnt_r;
    steps_nxt      = steps_r;
    pend_nxt       = pend_r;
    out_res_nxt    = out_res_r;

    a_wr_en   = 1'b0;
    a_wr_addr = idx_r;
    a_wr_data = '0;
    a_rd_en   = 1'b0;
    a_rd_addr = idx_r;
    b_wr_en   = 1'b0;
    b_wr_addr = idx_r;
    b_wr_data = ctx_r;
    b_rd_en   = 1'b0;
    b_rd_addr = idx_r;

    emit     = 1'b0;
    res      = '0;
    res.last = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = cmd_t'(in_command);
          idx_ok_nxt = (in_entry_index < IDX_IN_W'(POOL_DEPTH));
          idx_nxt    = in_entry_index[IW-1:0];
          stv_nxt    = in_status_value;
          ctx_nxt    = in_context_value;
          lim_nxt    = (in_max_matches > LIM_W'(MAX_RESULTS)) ?
                       LIM_W'(MAX_RESULTS) : in_max_matches;
          state_nxt  = S_DISP;
        end
      end

      S_DISP: begin
        unique case (cmd_r)
          CMD_ADD: begin
            scan_nxt  = '0;
            state_nxt = S_ADD_SCAN;
          end
          CMD_POP: begin
            if (head_ok_r && busy_r[head_r]) begin
              a_rd_en   = 1'b1;
              a_rd_addr = head_r;
              state_nxt = S_POP;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_REMOVE: begin
            if (idx_ok_r) begin
              a_rd_en   = 1'b1;
              state_nxt = S_RM_IDX;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_SET_ST: begin
            if (idx_ok_r) begin
              a_rd_en   = 1'b1;
              state_nxt = S_ST_WR;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_GET_ST: begin
            if (idx_ok_r) begin
              a_rd_en   = 1'b1;
              state_nxt = S_GET_ST;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_IS_FREE: begin
            if (out_free) begin
              res.ok        = idx_ok_r;
              res.slot_free = idx_ok_r && !busy_r[idx_r];
              emit          = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          CMD_SET_CTX: begin
            if (out_free) begin
              if (idx_ok_r) begin
                b_wr_en          = 1'b1;
                ctx_v_nxt[idx_r] = 1'b1;
              end
              res.ok    = idx_ok_r;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_GET_CTX: begin
            if (idx_ok_r) begin
              b_rd_en   = 1'b1;
              state_nxt = S_GET_CTX;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_COLLECT: begin
            cur_nxt    = head_r;
            cur_ok_nxt = head_ok_r;
            cnt_nxt    = '0;
            steps_nxt  = '0;
            state_nxt  = S_CL_RD;
          end
          default: begin
            // unknown command: plain failure
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end

      // Lowest free slot, one busy bit per cycle
      S_ADD_SCAN: begin
        priority if (scan_r == SW'(POOL_DEPTH)) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!busy_r[scan_r[IW-1:0]]) begin
          free_nxt = scan_r[IW-1:0];
          if (head_ok_r) begin
            a_rd_en   = 1'b1;
            a_rd_addr = tail_r;
            state_nxt = S_ADD_LINK;
          end else begin
            state_nxt = S_ADD_NEW;
          end
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end

      // Tail word is back: relink it to the new slot, keep its status
      S_ADD_LINK: begin
        a_wr_en             = 1'b1;
        a_wr_addr           = tail_r;
        a_wr_data           = {free_r, a_status};
        link_ok_nxt[tail_r] = 1'b1;
        state_nxt           = S_ADD_NEW;
      end

      S_ADD_NEW: begin
        if (out_free) begin
          a_wr_en             = 1'b1;
          a_wr_addr           = free_r;
          a_wr_data           = {{IW{1'b0}}, STATUS_IDLE};
          b_wr_en             = 1'b1;
          b_wr_addr           = free_r;
          busy_nxt[free_r]    = 1'b1;
          link_ok_nxt[free_r] = 1'b0;
          st_v_nxt[free_r]    = 1'b1;
          ctx_v_nxt[free_r]   = 1'b1;
          tail_nxt            = free_r;
          if (!head_ok_r) begin
            head_nxt = free_r;
          end
          head_ok_nxt    = 1'b1;
          res.ok         = 1'b1;
          res.slot_index = SLOT_OUT_W'(free_r);
          emit           = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // Head link is back; free the old head
      S_POP: begin
        if (out_free) begin
          head_ok_nxt         = link_ok_r[head_r];
          head_nxt            = link_ok_r[head_r] ? a_link : '0;
          busy_nxt[head_r]    = 1'b0;
          link_ok_nxt[head_r] = 1'b0;
          st_v_nxt[head_r]    = 1'b0;
          ctx_v_nxt[head_r]   = 1'b0;
          res.ok              = 1'b1;
          emit                = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      S_RM_IDX: begin
        idx_link_nxt = a_link;
        scan_nxt     = '0;
        chk_v_nxt    = 1'b0;
        state_nxt    = S_RM_SCAN;
      end

      // Predecessor search: each read is issued in the cycle before its compare
      S_RM_SCAN: begin
        priority if (rm_match) begin
          pred_nxt       = chk_r;
          pred_found_nxt = 1'b1;
          pred_st_nxt    = a_status;
          state_nxt      = S_RM_FIN;
        end else if (scan_r == SW'(POOL_DEPTH)) begin
          pred_found_nxt = 1'b0;
          state_nxt      = S_RM_FIN;
        end else begin
          a_rd_en   = 1'b1;
          a_rd_addr = scan_r[IW-1:0];
          chk_nxt   = scan_r[IW-1:0];
          chk_v_nxt = 1'b1;
          scan_nxt  = scan_r + SW'(1);
        end
      end

      S_RM_FIN: begin
        if (out_free) begin
          if (pred_found_r) begin
            a_wr_en             = 1'b1;
            a_wr_addr           = pred_r;
            a_wr_data           = {idx_link_r, pred_st_r};
            link_ok_nxt[pred_r] = link_ok_r[idx_r];
          end
          if (head_ok_r && head_r == idx_r) begin
            head_ok_nxt = link_ok_r[idx_r];
            head_nxt    = link_ok_r[idx_r] ? idx_link_r : '0;
          end
          if (tail_r == idx_r) begin
            tail_nxt = pred_found_r ? pred_r : '0;
          end
          // clear last so it wins over the predecessor update
          busy_nxt[idx_r]    = 1'b0;
          link_ok_nxt[idx_r] = 1'b0;
          st_v_nxt[idx_r]    = 1'b0;
          ctx_v_nxt[idx_r]   = 1'b0;
          res.ok             = 1'b1;
          emit               = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      S_ST_WR: begin
        if (out_free) begin
          a_wr_en         = 1'b1;
          a_wr_data       = {a_link, stv_r};
          st_v_nxt[idx_r] = 1'b1;
          res.ok          = 1'b1;
          emit            = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_GET_ST: begin
        if (out_free) begin
          res.ok         = 1'b1;
          res.status_out = st_v_r[idx_r] ? a_status : STATUS_UNDEFINED;
          emit           = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_GET_CTX: begin
        if (out_free) begin
          res.ok          = 1'b1;
          res.context_out = ctx_v_r[idx_r] ? b_rd_data : '0;
          emit            = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      // List walk: fetch the current slot
      S_CL_RD: begin
        if (cur_ok_r && cnt_r < lim_r && steps_r < SW'(POOL_DEPTH)) begin
          a_rd_en   = 1'b1;
          a_rd_addr = cur_r;
          state_nxt = S_CL_CHK;
        end else begin
          state_nxt = S_CL_END;
        end
      end

      // A new match releases the pending one as a non-final result
      S_CL_CHK: begin
        if (!(cl_match && cnt_r != '0 && !out_free)) begin
          if (cl_match) begin
            if (cnt_r != '0) begin
              res.ok         = 1'b1;
              res.slot_index = SLOT_OUT_W'(pend_r);
              res.hit_count  = cnt_r;
              res.last       = 1'b0;
              emit           = 1'b1;
            end
            pend_nxt = cur_r;
            cnt_nxt  = cnt_r + LIM_W'(1);
          end
          cur_ok_nxt = link_ok_r[cur_r];
          cur_nxt    = a_link;
          steps_nxt  = steps_r + SW'(1);
          state_nxt  = S_CL_RD;
        end
      end

      S_CL_END: begin
        if (out_free) begin
          if (cnt_r != '0) begin
            res.ok         = 1'b1;
            res.slot_index = SLOT_OUT_W'(pend_r);
            res.hit_count  = cnt_r;
          end
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      link_ok_r   <= '0;
      st_v_r      <= '0;
      ctx_v_r     <= '0;
      head_ok_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      link_ok_r   <= link_ok_nxt;
      st_v_r      <= st_v_nxt;
      ctx_v_r     <= ctx_v_nxt;
      head_ok_r   <= head_ok_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    idx_ok_r     <= idx_ok_nxt;
    stv_r        <= stv_nxt;
    ctx_r        <= ctx_nxt;
    lim_r        <= lim_nxt;
    scan_r       <= scan_nxt;
    free_r       <= free_nxt;
    chk_r        <= chk_nxt;
    idx_link_r   <= idx_link_nxt;
    pred_r       <= pred_nxt;
    pred_found_r <= pred_found_nxt;
    pred_st_r    <= pred_st_nxt;
    cur_r        <= cur_nxt;
    cur_ok_r     <= cur_ok_nxt;
    cnt_r        <= cnt_nxt;
    steps_r      <= steps_nxt;
    pend_r       <= pend_nxt;
    out_res_r    <= out_res_nxt;
  end

  // A non-final result only comes from collect, with a real match
  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.last) |-> (out_res_r.ok && out_res_r.hit_count != '0))
    else $error("non-final result without a match");

  // The slot claimed by add is busy afterwards
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_NEW && out_free) |=> busy_r[$past(free_r)])
    else $error("added slot not marked busy");

  // A live head always names a pool slot
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_ok_r |-> (head_r < IW'(POOL_DEPTH - 1) || head_r == IW'(POOL_DEPTH - 1)))
    else $error("head pointer outside the pool");

  // Collect never reports more than its limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CL_RD || state_r == S_CL_CHK || state_r == S_CL_END)
      |-> (cnt_r <= lim_r))
    else $error("collect exceeded its match limit");

endmodule

// ===== dv/tb_slot_linked_request_queue.sv =====
// tb_slot_linked_request_queue: self-checking testbench of the slot-linked request queue.
// Directed table followed by phased random commands; results are checked against a predictor.
// Depends on rtl/core/slq_pkg.sv and rtl/core/slot_linked_request_queue.sv.
module tb_slot_linked_request_queue;
  import slq_pkg::*;

  localparam int POOL = POOL_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 304;
  localparam int DRAIN_CYCLES = 2 * POOL + 16;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_CMDS = 150;
  localparam res_t NO_CHECK = '0;

  // One row of stimulus; want is used only when chk is set
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_IN_W-1:0] idx;
    logic [STATUS_W-1:0] st;
    logic [CTX_W-1:0]    ctx;
    logic [LIM_W-1:0]    lim;
    bit                  chk;
    res_t                want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CMD_W-1:0] in_command;
  logic [IDX_IN_W-1:0] in_entry_index;
  logic [STATUS_W-1:0] in_status_value;
  logic [CTX_W-1:0] in_context_value;
  logic [LIM_W-1:0] in_max_matches;
  logic out_valid;
  logic out_ready;
  logic out_ok;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic [STATUS_W-1:0] out_status_out;
  logic [CTX_W-1:0] out_context_out;
  logic out_slot_free;
  logic [LIM_W-1:0] out_hit_count;
  logic out_last;

  // Typed expectation travelling with the offered transaction
  bit row_chk;
  res_t row_exp;

  // Queue model: busy bits, links, status, context, head and tail
  bit                  busy_q [POOL];
  bit                  link_v [POOL];
  logic [3:0]          link_q [POOL];
  logic [STATUS_W-1:0] stat_q [POOL];
  logic [CTX_W-1:0]    ctx_q  [POOL];
  bit                  head_v;
  logic [3:0]          head_q;
  logic [3:0]          tail_q;

  res_t pending_results[$];
  stim_row_t directed_rows[$];
  int mismatch_count = 0;
  int accepted_cmds = 0;
  int burst_left = 0;

  always #2 clk = ~clk;

  slot_linked_request_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_status_value  (in_status_value),
    .in_context_value (in_context_value),
    .in_max_matches   (in_max_matches),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_slot_index   (out_slot_index),
    .out_status_out   (out_status_out),
    .out_context_out  (out_context_out),
    .out_slot_free    (out_slot_free),
    .out_hit_count    (out_hit_count),
    .out_last         (out_last)
  );

  function automatic res_t mk_res(input bit ok, input logic [3:0] slot,
                                  input logic [3:0] st, input logic [31:0] ctx,
                                  input bit fr, input logic [4:0] cnt, input bit lst);
    res_t r;
    r.ok = ok;
    r.slot_index = slot;
    r.status_out = st;
    r.context_out = ctx;
    r.slot_free = fr;
    r.hit_count = cnt;
    r.last = lst;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic [3:0] cmd, input logic [7:0] idx,
                                       input logic [3:0] st, input logic [31:0] ctx,
                                       input logic [4:0] lim, input bit chk, input res_t want);
    stim_row_t r;
    r.cmd = cmd;
    r.idx = idx;
    r.st = st;
    r.ctx = ctx;
    r.lim = lim;
    r.chk = chk;
    r.want = want;
    return r;
  endfunction

  function automatic res_t fail_res();
    return mk_res(1'b0, 4'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b1);
  endfunction

  function automatic res_t done_res();
    return mk_res(1'b1, 4'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b1);
  endfunction

  task automatic clear_model_slot(input int s);
    busy_q[s] = 1'b0;
    link_v[s] = 1'b0;
    link_q[s] = 4'd0;
    stat_q[s] = STATUS_UNDEFINED;
    ctx_q[s] = 32'd0;
  endtask

  task automatic reset_queue_model();
    for (int s = 0; s < POOL; s++) clear_model_slot(s);
    head_v = 1'b0;
    head_q = 4'd0;
    tail_q = 4'd0;
  endtask

  // Apply one command to the queue model and queue the results it produces
  task automatic apply_queue_cmd(input logic [3:0] cmd, input logic [7:0] idx,
                                 input logic [3:0] stv, input logic [31:0] ctx,
                                 input logic [4:0] lim);
    int s;
    int ix;
    int lim_c;
    int cnt;
    int steps;
    int cur;
    bit cur_v;
    bit idx_ok;
    bit have;
    res_t held;
    idx_ok = (idx < POOL);
    ix = idx_ok ? int'(idx) : 0;
    lim_c = (lim > MAX_RESULTS) ? MAX_RESULTS : int'(lim);
    case (cmd)
      CMD_ADD: begin
        for (s = 0; s < POOL; s++) if (!busy_q[s]) break;
        if (s == POOL) begin
          pending_results.push_back(fail_res());
        end else begin
          // empty queue: the stale tail is not linked
          if (head_v) begin
            link_q[tail_q] = 4'(s);
            link_v[tail_q] = 1'b1;
          end else begin
            head_q = 4'(s);
            head_v = 1'b1;
          end
          link_v[s] = 1'b0;
          link_q[s] = 4'd0;
          tail_q = 4'(s);
          busy_q[s] = 1'b1;
          ctx_q[s] = ctx;
          stat_q[s] = STATUS_IDLE;
          pending_results.push_back(mk_res(1'b1, 4'(s), 4'd0, 32'd0, 1'b0, 5'd0, 1'b1));
        end
      end
      CMD_POP: begin
        if (head_v && busy_q[head_q]) begin
          // link is read before the slot is cleared; tail stays
          cur = int'(head_q);
          cur_v = link_v[cur];
          head_q = link_q[cur];
          clear_model_slot(cur);
          head_v = cur_v;
          if (!cur_v) head_q = 4'd0;
          pending_results.push_back(done_res());
        end else begin
          pending_results.push_back(fail_res());
        end
      end
      CMD_REMOVE: begin
        if (!idx_ok) begin
          pending_results.push_back(fail_res());
        end else begin
          // lowest predecessor takes over the removed slot's link
          for (s = 0; s < POOL; s++) if (link_v[s] && link_q[s] == 4'(ix)) break;
          if (s < POOL) begin
            link_v[s] = link_v[ix];
            link_q[s] = link_q[ix];
          end
          if (head_v && head_q == 4'(ix)) begin
            head_v = link_v[ix];
            head_q = link_v[ix] ? link_q[ix] : 4'd0;
          end
          if (tail_q == 4'(ix)) tail_q = (s < POOL) ? 4'(s) : 4'd0;
          clear_model_slot(ix);
          pending_results.push_back(done_res());
        end
      end
      CMD_SET_ST: begin
        if (idx_ok) stat_q[ix] = stv;
        pending_results.push_back(mk_res(idx_ok, 4'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b1));
      end
      CMD_GET_ST: begin
        pending_results.push_back(mk_res(idx_ok, 4'd0, idx_ok ? stat_q[ix] : STATUS_UNDEFINED,
                                         32'd0, 1'b0, 5'd0, 1'b1));
      end
      CMD_IS_FREE: begin
        pending_results.push_back(mk_res(idx_ok, 4'd0, 4'd0, 32'd0,
                                         idx_ok ? !busy_q[ix] : 1'b0, 5'd0, 1'b1));
      end
      CMD_SET_CTX: begin
        if (idx_ok) ctx_q[ix] = ctx;
        pending_results.push_back(mk_res(idx_ok, 4'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b1));
      end
      CMD_GET_CTX: begin
        pending_results.push_back(mk_res(idx_ok, 4'd0, 4'd0, idx_ok ? ctx_q[ix] : 32'd0,
                                         1'b0, 5'd0, 1'b1));
      end
      CMD_COLLECT: begin
        // walk from head; the last match found carries the last flag
        cnt = 0;
        steps = 0;
        cur_v = head_v;
        cur = int'(head_q);
        have = 1'b0;
        held = NO_CHECK;
        while (cur_v && cnt < lim_c && steps < POOL) begin
          if (stat_q[cur] == stv) begin
            if (have) pending_results.push_back(held);
            held = mk_res(1'b1, 4'(cur), 4'd0, 32'd0, 1'b0, 5'(cnt + 1), 1'b0);
            have = 1'b1;
            cnt++;
          end
          cur_v = link_v[cur];
          cur = int'(link_q[cur]);
          steps++;
        end
        if (cnt == 0) begin
          pending_results.push_back(fail_res());
        end else begin
          held.last = 1'b1;
          pending_results.push_back(held);
        end
      end
      default: begin
        pending_results.push_back(fail_res());
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: score result transactions, then predict accepted commands
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual ok=%0d slot=%0d cnt=%0d",
                   $time, out_ok, out_slot_index, out_hit_count);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_ok));
          check_field("slot_index", 32'(want.slot_index), 32'(out_slot_index));
          check_field("status_out", 32'(want.status_out), 32'(out_status_out));
          check_field("context_out", want.context_out, out_context_out);
          check_field("slot_free", 32'(want.slot_free), 32'(out_slot_free));
          check_field("hit_count", 32'(want.hit_count), 32'(out_hit_count));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
      if (in_valid && in_ready) begin
        apply_queue_cmd(in_command, in_entry_index, in_status_value, in_context_value,
                        in_max_matches);
        // a typed expectation replaces the predicted one
        if (row_chk) begin
          void'(pending_results.pop_back());
          pending_results.push_back(row_exp);
        end
        accepted_cmds++;
      end
    end
  end

  // Receiver: rotating stall patterns plus one long hold-off to back up the input
  initial begin
    int rx_cycle;
    int hold_left;
    bit hold_done;
    int mode;
    rx_cycle = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (!hold_done && accepted_cmds >= HOLD_AFTER_CMDS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      mode = (rx_cycle / 80) % 4;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Sender: offer one transaction, bursts with random gaps between them
  task automatic offer_cmd(input stim_row_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= r.cmd;
    in_entry_index <= r.idx;
    in_status_value <= r.st;
    in_context_value <= r.ctx;
    in_max_matches <= r.lim;
    row_chk <= r.chk;
    row_exp <= r.want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random commands in phases: fill, churn, drain and query
  task automatic run_random_cmds(input int n_items);
    int profile;
    int roll;
    int add_w;
    int drop_w;
    int coll_w;
    stim_row_t r;
    profile = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 30 == 0) profile = $urandom_range(0, 3);
      case (profile)
        0: begin add_w = 60; drop_w = 10; coll_w = 15; end
        1: begin add_w = 30; drop_w = 30; coll_w = 20; end
        2: begin add_w = 10; drop_w = 55; coll_w = 15; end
        default: begin add_w = 15; drop_w = 15; coll_w = 35; end
      endcase
      roll = $urandom_range(0, 99);
      r = mk_row(CMD_ADD, 8'd0, 4'd0, 32'd0, 5'd0, 1'b0, NO_CHECK);
      if (roll < add_w) r.cmd = CMD_ADD;
      else if (roll < add_w + drop_w) r.cmd = $urandom_range(0, 1) ? CMD_POP : CMD_REMOVE;
      else if (roll < add_w + drop_w + coll_w) r.cmd = CMD_COLLECT;
      else if (roll < 97) r.cmd = 4'($urandom_range(int'(CMD_SET_ST), int'(CMD_GET_CTX)));
      else r.cmd = 4'($urandom_range(9, 15));
      r.idx = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, POOL - 1))
                                            : 8'($urandom_range(POOL, 255));
      // a few status codes in use so that collects find matches
      r.st = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
      r.ctx = $urandom();
      r.lim = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
      offer_cmd(r);
    end
  endtask

  // Directed table, then random part, then drain and verdict
  initial begin
    reset_queue_model();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_ADD;
    in_entry_index <= '0;
    in_status_value <= '0;
    in_context_value <= '0;
    in_max_matches <= '0;
    row_chk <= 1'b0;
    row_exp <= NO_CHECK;

    // after reset
    directed_rows.push_back(mk_row(CMD_GET_ST, 8'd0, 4'd0, 32'd0, 5'd0, 1'b1,
                            mk_res(1'b1, 4'd0, STATUS_UNDEFINED, 32'd0, 1'b0, 5'd0, 1'b1)));
    directed_rows.push_back(mk_row(CMD_IS_FREE, 8'd15, 4'd0, 32'd0, 5'd0, 1'b1,
                            mk_res(1'b1, 4'd0, 4'd0, 32'd0, 1'b1, 5'd0, 1'b1)));
    directed_rows.push_back(mk_row(CMD_GET_CTX, 8'd3, 4'd0, 32'd0, 5'd0, 1'b1, done_res()));
    // pop and collect on an empty queue
    directed_rows.push_back(mk_row(CMD_POP, 8'd0, 4'd0, 32'd0, 5'd0, 1'b1, fail_res()));
    directed_rows.push_back(mk_row(CMD_COLLECT, 8'd0, STATUS_IDLE, 32'd0, 5'd16, 1'b1,
                            fail_res()));
    // first adds take the lowest slots
    directed_rows.push_back(mk_row(CMD_ADD, 8'd0, 4'd0, 32'hFFFF_FFFF, 5'd0, 1'b1,
                            mk_res(1'b1, 4'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b1)));
    directed_rows.push_back(mk_row(CMD_ADD, 8'd0, 4'd0, 32'd0, 5'd0, 1'b1,
                            mk_res(1'b1, 4'd1, 4'd0, 32'd0, 1'b0, 5'd0, 1'b1)));
    directed_rows.push_back(mk_row(CMD_ADD, 8'd0, 4'd0, 32'hA5A5_5A5A, 5'd0, 1'b1,
                            mk_res(1'b1, 4'd2, 4'd0, 32'd0, 1'b0, 5'd0, 1'b1)));
    directed_rows.push_back(mk_row(CMD_GET_CTX, 8'd0, 4'd0, 32'd0, 5'd0, 1'b1,
                            mk_res(1'b1, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b1)));
    // invalid indexes and unknown commands
    directed_rows.push_back(mk_row(CMD_GET_ST, 8'd255, 4'd0, 32'd0, 5'd0, 1'b1, fail_res()));
    directed_rows.push_back(mk_row(CMD_SET_ST, 8'd16, 4'd15, 32'd0, 5'd0, 1'b1, fail_res()));
    directed_rows.push_back(mk_row(CMD_SET_CTX, 8'd128, 4'd0, 32'h1234_5678, 5'd0, 1'b1,
                            fail_res()));
    directed_rows.push_back(mk_row(CMD_REMOVE, 8'd200, 4'd0, 32'd0, 5'd0, 1'b1, fail_res()));
    directed_rows.push_back(mk_row(CMD_IS_FREE, 8'd16, 4'd0, 32'd0, 5'd0, 1'b1, fail_res()));
    directed_rows.push_back(mk_row(4'hF, 8'd0, 4'd0, 32'd0, 5'd0, 1'b1, fail_res()));
    directed_rows.push_back(mk_row(4'h9, 8'd1, 4'd1, 32'd0, 5'd16, 1'b1, fail_res()));
    // status changes and collects, zero limit and over-range limit
    directed_rows.push_back(mk_row(CMD_SET_ST, 8'd1, 4'd15, 32'd0, 5'd0, 1'b0, NO_CHECK));
    directed_rows.push_back(mk_row(CMD_COLLECT, 8'd0, STATUS_IDLE, 32'd0, 5'd16, 1'b0,
                            NO_CHECK));
    directed_rows.push_back(mk_row(CMD_COLLECT, 8'd0, STATUS_IDLE, 32'd0, 5'd0, 1'b1,
                            fail_res()));
    directed_rows.push_back(mk_row(CMD_COLLECT, 8'd0, 4'd15, 32'd0, 5'd31, 1'b0, NO_CHECK));
    // remove from the middle, write a free slot, remove the tail
    directed_rows.push_back(mk_row(CMD_REMOVE, 8'd1, 4'd0, 32'd0, 5'd0, 1'b0, NO_CHECK));
    directed_rows.push_back(mk_row(CMD_SET_CTX, 8'd9, 4'd0, 32'h1234_5678, 5'd0, 1'b0,
                            NO_CHECK));
    directed_rows.push_back(mk_row(CMD_GET_CTX, 8'd9, 4'd0, 32'd0, 5'd0, 1'b0, NO_CHECK));
    directed_rows.push_back(mk_row(CMD_REMOVE, 8'd2, 4'd0, 32'd0, 5'd0, 1'b0, NO_CHECK));
    // pop the last one, then add to the empty queue with a stale tail
    directed_rows.push_back(mk_row(CMD_POP, 8'd0, 4'd0, 32'd0, 5'd0, 1'b0, NO_CHECK));
    directed_rows.push_back(mk_row(CMD_ADD, 8'd0, 4'd0, 32'h0F0F_F0F0, 5'd0, 1'b0, NO_CHECK));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) offer_cmd(directed_rows[i]);
    run_random_cmds(RANDOM_ITEMS);
    in_valid <= 1'b0;
    row_chk <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
